### rtl/assert_macros.svh
// assertion helpers, empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

### rtl/bcssr_pkg.sv
package bcssr_pkg;

  localparam int unsigned LevelW = 8;
  localparam int unsigned CountW = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 12;

  localparam logic [LevelW-1:0] LevelMax = '1;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MOTOR_STEP = 3'd0,
    REG_LIGHT_STEP = 3'd1,
    REG_SHORT_MIN  = 3'd2,
    REG_SHORT_MAX  = 3'd3,
    REG_MEDIUM_MIN = 3'd4,
    REG_MEDIUM_MAX = 3'd5,
    REG_LONG_MIN   = 3'd6
  } bcssr_reg_e;

  typedef enum logic {
    KIND_TICK   = 1'b0,
    KIND_SAMPLE = 1'b1
  } bcssr_kind_e;

  typedef struct packed {
    logic kind;
    logic button_pressed;
  } bcssr_in_t;

  typedef struct packed {
    logic [LevelW-1:0] motor_compare;
    logic [LevelW-1:0] light_compare;
    logic              full_speed_led;
    logic              motor_enabled;
    logic              light_enabled;
  } bcssr_out_t;

  typedef struct packed {
    logic [LevelW-1:0] motor_step;
    logic [LevelW-1:0] light_step;
    logic [CountW-1:0] short_min;
    logic [CountW-1:0] short_max;
    logic [CountW-1:0] medium_min;
    logic [CountW-1:0] medium_max;
    logic [CountW-1:0] long_min;
  } bcssr_cfg_t;

  typedef struct packed {
    logic motor;
    logic light;
  } bcssr_on_t;

endpackage

### rtl/bcssr_cfg.sv
module bcssr_cfg
  import bcssr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output bcssr_cfg_t          cfg_o
);

  bcssr_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MOTOR_STEP: cfg_d.motor_step = cfg_data_i[LevelW-1:0];
        REG_LIGHT_STEP: cfg_d.light_step = cfg_data_i[LevelW-1:0];
        REG_SHORT_MIN:  cfg_d.short_min  = cfg_data_i[CountW-1:0];
        REG_SHORT_MAX:  cfg_d.short_max  = cfg_data_i[CountW-1:0];
        REG_MEDIUM_MIN: cfg_d.medium_min = cfg_data_i[CountW-1:0];
        REG_MEDIUM_MAX: cfg_d.medium_max = cfg_data_i[CountW-1:0];
        REG_LONG_MIN:   cfg_d.long_min   = cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motor_step <= LevelW'(3);
      cfg_q.light_step <= LevelW'(3);
      cfg_q.short_min  <= CountW'(5);
      cfg_q.short_max  <= CountW'(100);
      cfg_q.medium_min <= CountW'(150);
      cfg_q.medium_max <= CountW'(300);
      cfg_q.long_min   <= CountW'(350);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/bcssr_ramp.sv
module bcssr_ramp
  import bcssr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              up_i,
  input  logic [LevelW-1:0] step_i,
  output logic [LevelW-1:0] level_o,
  output logic [LevelW-1:0] level_next_o
);

  logic [LevelW-1:0] level_q, level_d;
  logic [LevelW:0]   sum;

  assign sum = {1'b0, level_q} + {1'b0, step_i};

  always_comb begin
    level_d = level_q;
    if (en_i) begin
      if (up_i) begin
        level_d = sum[LevelW] ? LevelMax : sum[LevelW-1:0];
      end else begin
        level_d = (step_i >= level_q) ? '0 : level_q - step_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;
  assign level_next_o = level_d;

endmodule

### rtl/bcssr_button.sv
module bcssr_button
  import bcssr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       pressed_i,
  input  bcssr_cfg_t cfg_i,
  output bcssr_on_t  on_o,
  output bcssr_on_t  on_next_o
);

  bcssr_on_t         on_q, on_d;
  logic [CountW-1:0] count_q, count_d;
  logic              was_pressed_q, was_pressed_d;
  logic              is_short, is_medium, is_long;

  assign is_short  = (cfg_i.short_min < count_q) && (count_q < cfg_i.short_max);
  assign is_medium = (cfg_i.medium_min < count_q) && (count_q < cfg_i.medium_max);
  assign is_long   = cfg_i.long_min < count_q;

  always_comb begin
    on_d = on_q;
    count_d = count_q;
    was_pressed_d = was_pressed_q;
    if (en_i) begin
      was_pressed_d = pressed_i;
      if (pressed_i) begin
        if (!was_pressed_q) begin
          count_d = CountW'(1);
        end else if (count_q != CountMax) begin
          count_d = count_q + CountW'(1);
        end
      end else if (was_pressed_q) begin
        // release: classify the press
        if (is_short) begin
          on_d.motor = !on_q.motor;
        end
        if (is_medium) begin
          on_d.light = !on_q.light;
        end
        if (is_long) begin
          on_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q <= '0;
      count_q <= '0;
      was_pressed_q <= 1'b0;
    end else begin
      on_q <= on_d;
      count_q <= count_d;
      was_pressed_q <= was_pressed_d;
    end
  end

  assign on_o = on_q;
  assign on_next_o = on_d;

endmodule

### rtl/button_controlled_soft_start_ramp.sv
// Soft-start ramp for a motor and a light, driven by one button.
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat is either a PWM
// period tick (kind 0) or a button sample (kind 1, button_pressed level).
// Output channel (out_valid_o/out_ready_i/out_data_o): exactly one beat per
// input beat, in order, holding compare values, full-speed flag and on flags
// as they stand after that item.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): always
// ready; index 0..6 selects motor_step, light_step, short_min, short_max,
// medium_min, medium_max, long_min. Other indexes are ignored.
// A beat passes the input register, then the result register, before out_valid_o
// rises. Throughput: one beat per cycle unless the receiver stalls, set by the
// single pass of add, clamp and compare logic between the two registers.
// If the receiver stalls, the result register holds and the input register
// takes one more beat; after that in_ready_o drops until the output drains.
// Reset clears both levels, the on flags, the press counter and the
// registers to 3, 3, 5, 100, 150, 300, 350; no items are in flight.
module button_controlled_soft_start_ramp
  import bcssr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bcssr_in_t           in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bcssr_out_t          out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

`include "assert_macros.svh"

  bcssr_cfg_t        cfg;
  bcssr_in_t         in_q;
  logic              in_valid_q;
  bcssr_out_t        out_q, out_d;
  logic              out_valid_q;
  logic              advance;
  logic              tick_en, sample_en;
  logic [LevelW-1:0] motor_level, motor_level_d, light_level, light_level_d;
  bcssr_on_t         on, on_d;

  assign advance = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign tick_en = advance && (in_q.kind == KIND_TICK);
  assign sample_en = advance && (in_q.kind == KIND_SAMPLE);

  bcssr_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  bcssr_ramp u_motor (
    .clk_i,
    .rst_ni,
    .en_i         (tick_en),
    .up_i         (on.motor),
    .step_i       (cfg.motor_step),
    .level_o      (motor_level),
    .level_next_o (motor_level_d)
  );

  bcssr_ramp u_light (
    .clk_i,
    .rst_ni,
    .en_i         (tick_en),
    .up_i         (on.light),
    .step_i       (cfg.light_step),
    .level_o      (light_level),
    .level_next_o (light_level_d)
  );

  bcssr_button u_button (
    .clk_i,
    .rst_ni,
    .en_i      (sample_en),
    .pressed_i (in_q.button_pressed),
    .cfg_i     (cfg),
    .on_o      (on),
    .on_next_o (on_d)
  );

  always_comb begin
    out_d.motor_compare  = LevelMax - motor_level_d;
    out_d.light_compare  = light_level_d;
    out_d.full_speed_led = motor_level_d == LevelMax;
    out_d.motor_enabled  = on_d.motor;
    out_d.light_enabled  = on_d.light;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  // full-speed flag tracks a zero motor compare
  `ASSERT_AT(a_full_speed, clk_i, rst_ni,
    !out_valid_q || (out_q.full_speed_led == (out_q.motor_compare == '0)))
  // a processed beat always lands in the result register
  `ASSERT_NEXT(a_adv_out, clk_i, rst_ni, advance, out_valid_q)
  // a tick never changes the on flags
  `ASSERT_NEXT(a_tick_on, clk_i, rst_ni, tick_en,
    (out_q.motor_enabled == $past(on.motor)) && (out_q.light_enabled == $past(on.light)))
  // a button sample never moves either level
  `ASSERT_NEXT(a_sample_lvl, clk_i, rst_ni, sample_en,
    (out_q.light_compare == $past(light_level)) &&
    (out_q.motor_compare == LevelMax - $past(motor_level)))

endmodule

### tb/testbench.sv
module testbench;
  import bcssr_pkg::*;

  localparam int unsigned HalfPeriod = 10;
  localparam int unsigned ResetCycles = 9;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned LimitTime = 20_000_000;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  bcssr_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bcssr_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  button_controlled_soft_start_ramp dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #(HalfPeriod) clk = ~clk;

  // predicted controller state
  bcssr_cfg_t ramp_cfg;
  bcssr_on_t chan_on;
  logic [LevelW-1:0] motor_lvl;
  logic [LevelW-1:0] light_lvl;
  logic [CountW-1:0] press_len;
  logic btn_held;

  bcssr_in_t tick_sample_q[$];
  bcssr_out_t levels_due_q[$];
  bcssr_out_t due_beat;

  int items_queued = 0;
  int items_accepted = 0;
  int fail_count = 0;
  int tick_count = 0;
  int sample_count = 0;
  int release_count = 0;
  int cfg_writes = 0;

  logic in_taken = 1'b0;
  bit sender_bursty = 1'b0;
  bit recv_stalls = 1'b0;
  int gap_left = 0;
  int burst_left = 0;
  int hold_off_left = 0;
  int pattern_age = 0;
  logic [15:0] stall_pattern = 16'h5a5b;

  function automatic logic [LevelW-1:0] step_level(logic [LevelW-1:0] lvl,
                                                   logic [LevelW-1:0] stp, logic up);
    logic [LevelW:0] sum;
    sum = {1'b0, lvl} + {1'b0, stp};
    if (up) return sum[LevelW] ? LevelMax : sum[LevelW-1:0];
    return (stp >= lvl) ? '0 : lvl - stp;
  endfunction

  function automatic bcssr_out_t ramp_and_classify(bcssr_in_t item);
    bcssr_out_t res;
    if (bcssr_kind_e'(item.kind) == KIND_TICK) begin
      motor_lvl = step_level(motor_lvl, ramp_cfg.motor_step, chan_on.motor);
      light_lvl = step_level(light_lvl, ramp_cfg.light_step, chan_on.light);
      tick_count++;
    end else begin
      sample_count++;
      if (item.button_pressed) begin
        if (!btn_held) press_len = CountW'(1);
        else if (press_len != CountMax) press_len = press_len + CountW'(1);
        btn_held = 1'b1;
      end else begin
        if (btn_held) begin
          if (ramp_cfg.short_min < press_len && press_len < ramp_cfg.short_max)
            chan_on.motor = !chan_on.motor;
          if (ramp_cfg.medium_min < press_len && press_len < ramp_cfg.medium_max)
            chan_on.light = !chan_on.light;
          if (ramp_cfg.long_min < press_len) chan_on = '0;
          release_count++;
        end
        btn_held = 1'b0;
      end
    end
    res.motor_compare = LevelMax - motor_lvl;
    res.light_compare = light_lvl;
    res.full_speed_led = (motor_lvl == LevelMax);
    res.motor_enabled = chan_on.motor;
    res.light_enabled = chan_on.light;
    return res;
  endfunction

  task automatic check_field(string name, logic [LevelW-1:0] want, logic [LevelW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_flag(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // result beats checked before the input beat of the same edge is predicted
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (levels_due_q.size() == 0) begin
        $error("result beat with no prediction waiting");
        fail_count++;
      end else begin
        due_beat = levels_due_q.pop_front();
        check_field("motor_compare", due_beat.motor_compare, out_data.motor_compare);
        check_field("light_compare", due_beat.light_compare, out_data.light_compare);
        check_flag("full_speed_led", due_beat.full_speed_led, out_data.full_speed_led);
        check_flag("motor_enabled", due_beat.motor_enabled, out_data.motor_enabled);
        check_flag("light_enabled", due_beat.light_enabled, out_data.light_enabled);
      end
    end
    if (rst_n && in_valid && in_ready) begin
      levels_due_q.push_back(ramp_and_classify(in_data));
      items_accepted++;
    end
    in_taken <= in_valid && in_ready;
  end

  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (sender_bursty && gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (tick_sample_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= tick_sample_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else if (!recv_stalls) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      pattern_age++;
      if (pattern_age == 64) begin
        pattern_age = 0;
        stall_pattern = 16'($urandom()) | 16'h0001;
      end
    end
  end

  task automatic queue_item(bcssr_kind_e kind, logic btn);
    bcssr_in_t it;
    it.kind = kind;
    it.button_pressed = btn;
    tick_sample_q.push_back(it);
    items_queued++;
  endtask

  task automatic queue_press(int len);
    repeat (len) queue_item(KIND_SAMPLE, 1'b1);
    queue_item(KIND_SAMPLE, 1'b0);
  endtask

  task automatic queue_ticks(int n);
    repeat (n) queue_item(KIND_TICK, 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    while (!(items_accepted == items_queued && levels_due_q.size() == 0)) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MOTOR_STEP: ramp_cfg.motor_step = val[LevelW-1:0];
      REG_LIGHT_STEP: ramp_cfg.light_step = val[LevelW-1:0];
      REG_SHORT_MIN:  ramp_cfg.short_min = val;
      REG_SHORT_MAX:  ramp_cfg.short_max = val;
      REG_MEDIUM_MIN: ramp_cfg.medium_min = val;
      REG_MEDIUM_MAX: ramp_cfg.medium_max = val;
      REG_LONG_MIN:   ramp_cfg.long_min = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic program_cfg(logic [CfgDataW-1:0] m_step, logic [CfgDataW-1:0] l_step,
                             logic [CfgDataW-1:0] s_min, logic [CfgDataW-1:0] s_max,
                             logic [CfgDataW-1:0] md_min, logic [CfgDataW-1:0] md_max,
                             logic [CfgDataW-1:0] lg_min);
    write_reg(REG_MOTOR_STEP, m_step);
    write_reg(REG_LIGHT_STEP, l_step);
    write_reg(REG_SHORT_MIN, s_min);
    write_reg(REG_SHORT_MAX, s_max);
    write_reg(REG_MEDIUM_MIN, md_min);
    write_reg(REG_MEDIUM_MAX, md_max);
    write_reg(REG_LONG_MIN, lg_min);
    write_reg(RegUnused, CfgDataW'($urandom()));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CfgDataW-1:0] pick_step();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CfgDataW'(1);
      2: return CfgDataW'(255);
      3: return CfgDataW'($urandom());
      default: return CfgDataW'($urandom_range(2, 20));
    endcase
  endfunction

  task automatic program_random_cfg();
    int s_min, md_min;
    s_min = $urandom_range(0, 4);
    md_min = $urandom_range(2, 14);
    program_cfg(pick_step(), pick_step(), CfgDataW'(s_min),
                CfgDataW'(s_min + $urandom_range(0, 8)), CfgDataW'(md_min),
                CfgDataW'(md_min + $urandom_range(0, 10)),
                CfgDataW'($urandom_range(6, 30)));
  endtask

  // whole presses sized around the bounds, mixed with tick runs and stray beats
  task automatic run_phase(int n_items, int cap);
    int added, len, thr;
    added = 0;
    while (added < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          case ($urandom_range(0, 4))
            0: thr = int'(ramp_cfg.short_min);
            1: thr = int'(ramp_cfg.short_max);
            2: thr = int'(ramp_cfg.medium_min);
            3: thr = int'(ramp_cfg.medium_max);
            default: thr = int'(ramp_cfg.long_min);
          endcase
          len = thr + $urandom_range(0, 2) - 1;
          if (len < 1) len = 1;
          if (len > cap) len = $urandom_range(1, cap);
          queue_press(len);
          added += len + 1;
        end
        4, 5, 6: begin
          len = $urandom_range(1, 6);
          queue_ticks(len);
          added += len;
        end
        default: begin
          queue_item(bcssr_kind_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          added++;
        end
      endcase
    end
    wait_drained();
  endtask

  initial begin
    #(LimitTime);
    $display("Verification failed");
    $finish;
  end

  initial begin
    ramp_cfg = '{motor_step: 8'd3, light_step: 8'd3, short_min: 12'd5, short_max: 12'd100,
                 medium_min: 12'd150, medium_max: 12'd300, long_min: 12'd350};
    chan_on = '0;
    motor_lvl = '0;
    light_lvl = '0;
    press_len = '0;
    btn_held = 1'b0;

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    recv_stalls = 1'b1;

    // reset values: ignored button on a tick, idle release, short press
    queue_item(KIND_TICK, 1'b1);
    queue_item(KIND_SAMPLE, 1'b0);
    queue_press(6);
    queue_item(KIND_TICK, 1'b0);
    wait_drained();

    // tight bounds with full steps: every press class and both clamps
    program_cfg(255, 255, 0, 3, 2, 5, 4);
    queue_press(1);
    queue_item(KIND_TICK, 1'b0);
    queue_press(3);
    queue_item(KIND_TICK, 1'b1);
    queue_press(2);
    queue_item(KIND_TICK, 1'b0);
    queue_press(5);
    queue_item(KIND_TICK, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      sender_bursty = (phase != 2 && phase != 3);
      recv_stalls = (phase != 3) && ($urandom_range(0, 3) != 0);
      case (phase)
        6: program_cfg(255, 0, 0, 0, 4095, 0, 0);
        7: program_cfg(3, 3, 5, 100, 150, 300, 350);
        default: program_random_cfg();
      endcase
      if (phase == 2) begin
        @(posedge clk);
        hold_off_left = HoldOffCycles;
      end
      run_phase((phase == 7) ? 60 : 230, (phase == 7) ? 400 : 64);
    end

    if (levels_due_q.size() != 0) begin
      $error("%0d predicted results never arrived", levels_due_q.size());
      fail_count++;
    end
    $display("run covered %0d ticks and %0d button samples with %0d classified releases",
             tick_count, sample_count, release_count);
    $display("across %0d register writes; %0d mismatches", cfg_writes, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/bcssr_pkg.sv
rtl/bcssr_cfg.sv
rtl/bcssr_ramp.sv
rtl/bcssr_button.sv
rtl/button_controlled_soft_start_ramp.sv
tb/testbench.sv
